/* sv/sqb_pkg.sv */
// shared types, constants and the sine table generator of the sprite quad batcher
package sqb_pkg;

   localparam int unsigned MAX_GROUPS_DEF          = 16;
   localparam int unsigned MAX_QUADS_PER_GROUP_DEF = 1024;
   localparam int unsigned SINE_TABLE_BITS_DEF     = 10;
   localparam int unsigned QUEUE_DEPTH             = 2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [16:0] ONE_Q15     = 17'd32768;

   typedef enum logic [1:0] {
      ST_VERTEX  = 2'd0,
      ST_DROPPED = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FLIP_NONE  = 2'd0,
      FLIP_HORIZ = 2'd1,
      FLIP_VERT  = 2'd2,
      FLIP_BOTH  = 2'd3
   } flip_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SIN,
      B_COS,
      B_CAP,
      B_MUL,
      B_OUT
   } back_state_type;

   // classified request handed from front to back
   typedef struct packed {
      status_type   status;
      logic [3:0]   slot;
      logic [9:0]   quad;
      logic [15:0]  total;
      logic [23:0]  dst_x;
      logic [23:0]  dst_y;
      logic [22:0]  dst_w;
      logic [22:0]  dst_h;
      logic [63:0]  src_rect;
      logic [15:0]  rotation;
      logic [47:0]  pivot;
      logic [1:0]   flip;
      logic [31:0]  color;
   } entry_type;

   typedef struct packed {
      logic [23:0]  vertex_x;
      logic [23:0]  vertex_y;
      logic [16:0]  tex_u;
      logic [16:0]  tex_v;
      logic [31:0]  vertex_color;
      logic [3:0]   group_slot;
      logic [9:0]   quad_index;
      logic [1:0]   corner;
      logic         last;
      logic [1:0]   status;
      logic [15:0]  sprite_total;
   } result_type;

   // quarter-wave sine in q1.15, taylor series in q30
   function automatic logic [15:0] quarter_sine(input int unsigned r, input int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (64'(r) * HALF_PI_Q30) >> (bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 5; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            default: term = term / 110;
         endcase
         if (n % 2 == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
         sum = 64'sd32768;
      end
      return sum[15:0];
   endfunction

endpackage

/* sv/sqb_if.sv */
// request and result channel interfaces of the sprite quad batcher
interface sqb_req_if;
   logic         valid;
   logic         ready;
   logic         cmd;
   logic [15:0]  texture_id;
   logic [7:0]   layer;
   logic [23:0]  dst_x;
   logic [23:0]  dst_y;
   logic [22:0]  dst_w;
   logic [22:0]  dst_h;
   logic [63:0]  src_rect;
   logic [15:0]  rotation;
   logic [47:0]  pivot;
   logic [1:0]   flip;
   logic [31:0]  color;

   modport source (output valid, cmd, texture_id, layer, dst_x, dst_y, dst_w, dst_h,
                   src_rect, rotation, pivot, flip, color, input ready);
   modport sink (input valid, cmd, texture_id, layer, dst_x, dst_y, dst_w, dst_h,
                 src_rect, rotation, pivot, flip, color, output ready);
endinterface

interface sqb_rsp_if;
   logic         valid;
   logic         ready;
   logic [23:0]  vertex_x;
   logic [23:0]  vertex_y;
   logic [16:0]  tex_u;
   logic [16:0]  tex_v;
   logic [31:0]  vertex_color;
   logic [3:0]   group_slot;
   logic [9:0]   quad_index;
   logic [1:0]   corner;
   logic         last;
   logic [1:0]   status;
   logic [15:0]  sprite_total;

   modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color,
                   group_slot, quad_index, corner, last, status, sprite_total,
                   input ready);
   modport sink (input valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color,
                 group_slot, quad_index, corner, last, status, sprite_total,
                 output ready);
endinterface

/* sv/sprite_quad_batcher.sv */
// top level of the sprite quad batcher
//
//   channel    direction  handshake         carries
//   req_chan   in         valid/ready       draw or clear request
//   rsp_chan   out        valid/ready       vertex or status result
//   csr_*      in         write enable      invalid texture id
//
// in the front a draw request scans the group table one slot per cycle until a hit or the
// last slot; the back takes each sprite through a pop, two sine table reads and a capture,
// then a multiply and an output step for each corner, the output waiting on rsp_chan.ready;
// status requests go straight to the push state in the front and are loaded on pop in the back
// reset is synchronous and clears group valid bits and the sprite count at once
// a two-entry queue lets the front classify while the back waits on rsp_chan.ready
module sprite_quad_batcher #(
   parameter int unsigned MAX_GROUPS          = sqb_pkg::MAX_GROUPS_DEF,
   parameter int unsigned MAX_QUADS_PER_GROUP = sqb_pkg::MAX_QUADS_PER_GROUP_DEF,
   parameter int unsigned SINE_TABLE_BITS     = sqb_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sqb_req_if.sink      req_chan,
   sqb_rsp_if.source    rsp_chan,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   logic                push_valid;
   logic                push_ready;
   sqb_pkg::entry_type  push_data;
   logic                pop_valid;
   logic                pop_ready;
   sqb_pkg::entry_type  pop_data;

   sqb_front #(
      .MAX_GROUPS          (MAX_GROUPS),
      .MAX_QUADS_PER_GROUP (MAX_QUADS_PER_GROUP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sqb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   sqb_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* sv/sqb_front.sv */
// request classification and batch group table
module sqb_front #(
   parameter int unsigned MAX_GROUPS          = sqb_pkg::MAX_GROUPS_DEF,
   parameter int unsigned MAX_QUADS_PER_GROUP = sqb_pkg::MAX_QUADS_PER_GROUP_DEF
) (
   input  logic                clock,
   input  logic                reset,
   sqb_req_if.sink             req_chan,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                push_valid,
   input  logic                push_ready,
   output sqb_pkg::entry_type  push_data
);

   localparam int unsigned SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int unsigned IW = $clog2(MAX_GROUPS + 1);
   localparam int unsigned CW = $clog2(MAX_QUADS_PER_GROUP + 1);
   localparam int unsigned MW = 24 + CW;

   sqb_pkg::front_state_type state_ff, state_in;

   logic [15:0]            inv_ff;
   logic [15:0]            cnt_ff;
   logic [15:0]            cnt_inc;
   logic [MAX_GROUPS-1:0]  valid_ff;
   logic [MW-1:0]          mem [MAX_GROUPS];
   logic [MW-1:0]          mem_q_ff;
   logic [IW-1:0]          idx_ff;
   logic [SW-1:0]          rd_idx_ff;
   logic                   rd_vld_ff;
   logic                   free_vld_ff;
   logic [SW-1:0]          free_idx_ff;
   sqb_pkg::entry_type     entry_ff;
   logic [15:0]            tex_ff;
   logic [7:0]             layer_ff;

   logic                   accept;
   logic                   hit;
   logic                   last_rd;
   logic                   cur_free;
   logic                   free_ok;
   logic [SW-1:0]          free_slot;
   logic                   decide;
   logic [CW-1:0]          hit_count;
   logic                   count_full;

   assign accept     = req_chan.valid && req_chan.ready;
   assign hit_count  = mem_q_ff[CW-1:0];
   assign count_full = hit_count >= CW'(MAX_QUADS_PER_GROUP);
   assign hit        = rd_vld_ff && valid_ff[rd_idx_ff] &&
                       mem_q_ff[MW-1 -: 16] == tex_ff &&
                       mem_q_ff[MW-17 -: 8] == layer_ff;
   assign last_rd    = rd_vld_ff && rd_idx_ff == SW'(MAX_GROUPS - 1);
   assign cur_free   = rd_vld_ff && !valid_ff[rd_idx_ff];
   assign free_ok    = free_vld_ff || cur_free;
   assign free_slot  = free_vld_ff ? free_idx_ff : rd_idx_ff;
   assign decide     = (state_ff == sqb_pkg::F_SCAN) && (hit || last_rd);
   assign cnt_inc    = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
   assign push_data  = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqb_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      case (state_ff)
         sqb_pkg::F_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.cmd || req_chan.texture_id == inv_ff) begin
                  state_in = sqb_pkg::F_PUSH;
               end else begin
                  state_in = sqb_pkg::F_SCAN;
               end
            end
         end
         sqb_pkg::F_SCAN: begin
            if (decide) begin
               state_in = sqb_pkg::F_PUSH;
            end
         end
         sqb_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = sqb_pkg::F_IDLE;
            end
         end
         default: state_in = sqb_pkg::F_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff      <= '0;
         cnt_ff      <= '0;
         valid_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         free_vld_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         if (csr_we) begin
            inv_ff <= csr_wdata;
         end
         if (accept) begin
            idx_ff      <= '0;
            rd_vld_ff   <= 1'b0;
            free_vld_ff <= 1'b0;
            if (req_chan.cmd) begin
               valid_ff <= '0;
               cnt_ff   <= '0;
            end
         end else if (state_ff == sqb_pkg::F_SCAN) begin
            if (idx_ff < IW'(MAX_GROUPS)) begin
               rd_vld_ff <= 1'b1;
               idx_ff    <= idx_ff + IW'(1);
            end else begin
               rd_vld_ff <= 1'b0;
            end
            if (cur_free && !free_vld_ff) begin
               free_vld_ff <= 1'b1;
            end
            if (decide) begin
               if (hit) begin
                  if (!count_full) begin
                     cnt_ff <= cnt_inc;
                  end
               end else if (free_ok) begin
                  valid_ff[free_slot] <= 1'b1;
                  cnt_ff              <= cnt_inc;
               end
            end
         end
      end
   end

   // group table and request payload
   always_ff @(posedge clock) begin
      if (state_ff == sqb_pkg::F_SCAN) begin
         if (idx_ff < IW'(MAX_GROUPS)) begin
            mem_q_ff  <= mem[idx_ff[SW-1:0]];
            rd_idx_ff <= idx_ff[SW-1:0];
         end
         if (cur_free && !free_vld_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
         if (decide) begin
            if (hit && !count_full) begin
               mem[rd_idx_ff]  <= {tex_ff, layer_ff, hit_count + CW'(1)};
               entry_ff.status <= sqb_pkg::ST_VERTEX;
               entry_ff.slot   <= 4'(rd_idx_ff);
               entry_ff.quad   <= 10'(hit_count);
               entry_ff.total  <= cnt_inc;
            end else if (!hit && free_ok) begin
               mem[free_slot]  <= {tex_ff, layer_ff, CW'(1)};
               entry_ff.status <= sqb_pkg::ST_VERTEX;
               entry_ff.slot   <= 4'(free_slot);
               entry_ff.quad   <= '0;
               entry_ff.total  <= cnt_inc;
            end else begin
               entry_ff.status <= sqb_pkg::ST_FULL;
               entry_ff.total  <= cnt_ff;
            end
         end
      end
      if (accept) begin
         tex_ff            <= req_chan.texture_id;
         layer_ff          <= req_chan.layer;
         entry_ff.slot     <= '0;
         entry_ff.quad     <= '0;
         entry_ff.total    <= req_chan.cmd ? 16'd0 : cnt_ff;
         entry_ff.status   <= req_chan.cmd ? sqb_pkg::ST_CLEARED : sqb_pkg::ST_DROPPED;
         entry_ff.dst_x    <= req_chan.dst_x;
         entry_ff.dst_y    <= req_chan.dst_y;
         entry_ff.dst_w    <= req_chan.dst_w;
         entry_ff.dst_h    <= req_chan.dst_h;
         entry_ff.src_rect <= req_chan.src_rect;
         entry_ff.rotation <= req_chan.rotation;
         entry_ff.pivot    <= req_chan.pivot;
         entry_ff.flip     <= req_chan.flip;
         entry_ff.color    <= req_chan.color;
      end
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd) |=> (valid_ff == '0 && cnt_ff == '0))
      else $error("clear left groups or count behind");

   a_new_group_valid: assert property (@(posedge clock) disable iff (reset)
      (decide && !hit && free_ok) |=> valid_ff[$past(free_slot)])
      else $error("new group slot not marked valid");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(accept && req_chan.cmd) |=> cnt_ff >= $past(cnt_ff))
      else $error("sprite count went backwards without clear");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(MAX_GROUPS))
      else $error("scan index ran past group table");

endmodule

/* sv/sqb_fifo.sv */
// short queue between classification and vertex generation
module sqb_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sqb_pkg::entry_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sqb_pkg::entry_type  out_data
);

   localparam int unsigned DEPTH = sqb_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned NW    = $clog2(DEPTH + 1);

   sqb_pkg::entry_type  slots_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       rd_ptr_ff;
   logic [NW-1:0]       fill_ff;
   logic                push;
   logic                pop;

   assign in_ready  = fill_ff < NW'(DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + NW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* sv/sqb_back.sv */
// rotation, texture coordinates and vertex output sequencer
module sqb_back #(
   parameter int unsigned SINE_TABLE_BITS = sqb_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  sqb_pkg::entry_type  pop_data,
   sqb_rsp_if.source           rsp_chan
);

   localparam int unsigned B       = SINE_TABLE_BITS;
   localparam int unsigned QUARTER = 1 << (B - 2);
   localparam int unsigned AW      = B - 1;

   typedef logic [15:0] qtab_type [QUARTER + 1];

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int r = 0; r <= int'(QUARTER); r++) begin
         t[r] = sqb_pkg::quarter_sine(r, B);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   sqb_pkg::back_state_type state_ff, state_in;

   sqb_pkg::entry_type   cur_ff;
   sqb_pkg::result_type  out_ff;
   logic                 out_vld_ff;
   logic [1:0]           corner_ff;
   logic [15:0]          rom_q_ff;
   logic                 rom_neg_ff;
   logic signed [16:0]   c_ff;
   logic signed [16:0]   s_ff;
   logic signed [41:0]   p_xc_ff;
   logic signed [41:0]   p_ys_ff;
   logic signed [41:0]   p_xs_ff;
   logic signed [41:0]   p_yc_ff;

   logic                 out_free;
   logic                 load_single;
   logic                 load_vertex;
   logic [B-1:0]         sin_idx;
   logic [B-1:0]         rom_idx;
   logic [AW-1:0]        rom_addr;
   logic [B-3:0]         rom_r;
   logic signed [16:0]   rom_val;
   logic [1:0]           k;
   logic signed [23:0]   pvx;
   logic signed [23:0]   pvy;
   logic signed [24:0]   dx;
   logic signed [24:0]   dy;
   logic signed [24:0]   px;
   logic signed [24:0]   py;
   logic signed [42:0]   sum_x;
   logic signed [42:0]   sum_y;
   logic signed [27:0]   rx;
   logic signed [27:0]   ry;
   logic signed [28:0]   vx;
   logic signed [28:0]   vy;
   logic [23:0]          sat_x;
   logic [23:0]          sat_y;
   logic [15:0]          su;
   logic [15:0]          sv;
   logic [15:0]          sw;
   logic [15:0]          sh;
   logic [16:0]          u0;
   logic [16:0]          v0;
   logic [16:0]          u1;
   logic [16:0]          v1;

   assign out_free = !out_vld_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqb_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pop_ready   = 1'b0;
      load_single = 1'b0;
      load_vertex = 1'b0;
      case (state_ff)
         sqb_pkg::B_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               if (pop_data.status == sqb_pkg::ST_VERTEX) begin
                  state_in = sqb_pkg::B_SIN;
               end else begin
                  load_single = 1'b1;
               end
            end
         end
         sqb_pkg::B_SIN: state_in = sqb_pkg::B_COS;
         sqb_pkg::B_COS: state_in = sqb_pkg::B_CAP;
         sqb_pkg::B_CAP: state_in = sqb_pkg::B_MUL;
         sqb_pkg::B_MUL: state_in = sqb_pkg::B_OUT;
         sqb_pkg::B_OUT: begin
            if (out_free) begin
               load_vertex = 1'b1;
               state_in = (corner_ff == 2'd3) ? sqb_pkg::B_IDLE : sqb_pkg::B_MUL;
            end
         end
         default: state_in = sqb_pkg::B_IDLE;
      endcase
   end

   // quarter-wave table address for sine, then cosine a quarter turn on
   always_comb begin
      sin_idx  = cur_ff.rotation[15 -: B];
      rom_idx  = (state_ff == sqb_pkg::B_COS) ? sin_idx + B'(QUARTER) : sin_idx;
      rom_r    = rom_idx[B-3:0];
      rom_addr = rom_idx[B-2] ? AW'(QUARTER) - {1'b0, rom_r} : {1'b0, rom_r};
      rom_val  = rom_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
   end

   always_comb begin
      case (sqb_pkg::flip_type'(cur_ff.flip))
         sqb_pkg::FLIP_HORIZ: k = corner_ff ^ 2'd1;
         sqb_pkg::FLIP_VERT:  k = ~corner_ff;
         default:             k = corner_ff;
      endcase
      pvx = $signed(cur_ff.pivot[23:0]);
      pvy = $signed(cur_ff.pivot[47:24]);
      if (k == 2'd1 || k == 2'd2) begin
         dx = $signed({2'b00, cur_ff.dst_w}) - {pvx[23], pvx};
      end else begin
         dx = -{pvx[23], pvx};
      end
      if (k == 2'd2 || k == 2'd3) begin
         dy = $signed({2'b00, cur_ff.dst_h}) - {pvy[23], pvy};
      end else begin
         dy = -{pvy[23], pvy};
      end
      px    = $signed({cur_ff.dst_x[23], cur_ff.dst_x}) + {pvx[23], pvx};
      py    = $signed({cur_ff.dst_y[23], cur_ff.dst_y}) + {pvy[23], pvy};
      sum_x = 43'(p_xc_ff) - 43'(p_ys_ff) + 43'sd16384;
      sum_y = 43'(p_xs_ff) + 43'(p_yc_ff) + 43'sd16384;
      rx    = sum_x[42:15];
      ry    = sum_y[42:15];
      vx    = 29'(rx) + 29'(px);
      vy    = 29'(ry) + 29'(py);
      if (vx > 29'sd8388607) begin
         sat_x = 24'h7FFFFF;
      end else if (vx < -29'sd8388608) begin
         sat_x = 24'h800000;
      end else begin
         sat_x = vx[23:0];
      end
      if (vy > 29'sd8388607) begin
         sat_y = 24'h7FFFFF;
      end else if (vy < -29'sd8388608) begin
         sat_y = 24'h800000;
      end else begin
         sat_y = vy[23:0];
      end
      su = cur_ff.src_rect[15:0];
      sv = cur_ff.src_rect[31:16];
      sw = cur_ff.src_rect[47:32];
      sh = cur_ff.src_rect[63:48];
      if (sw != '0 && sh != '0) begin
         u0 = {1'b0, su};
         v0 = {1'b0, sv};
         u1 = {1'b0, su} + {1'b0, sw};
         v1 = {1'b0, sv} + {1'b0, sh};
      end else begin
         u0 = '0;
         v0 = '0;
         u1 = sqb_pkg::ONE_Q15;
         v1 = sqb_pkg::ONE_Q15;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         corner_ff  <= '0;
      end else begin
         if (load_single || load_vertex) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
         if (state_ff == sqb_pkg::B_SIN) begin
            corner_ff <= '0;
         end else if (load_vertex) begin
            corner_ff <= corner_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff   <= QTAB[rom_addr];
      rom_neg_ff <= rom_idx[B-1];
      if (pop_ready) begin
         cur_ff <= pop_data;
      end
      if (state_ff == sqb_pkg::B_COS) begin
         s_ff <= rom_val;
      end
      if (state_ff == sqb_pkg::B_CAP) begin
         if (cur_ff.rotation == '0) begin
            c_ff <= sqb_pkg::ONE_Q15;
            s_ff <= '0;
         end else begin
            c_ff <= rom_val;
         end
      end
      if (state_ff == sqb_pkg::B_MUL) begin
         p_xc_ff <= dx * c_ff;
         p_ys_ff <= dy * s_ff;
         p_xs_ff <= dx * s_ff;
         p_yc_ff <= dy * c_ff;
      end
      if (load_single) begin
         out_ff <= '{last: 1'b1, status: pop_data.status, sprite_total: pop_data.total,
                     default: '0};
      end else if (load_vertex) begin
         out_ff.vertex_x     <= sat_x;
         out_ff.vertex_y     <= sat_y;
         out_ff.tex_u        <= (corner_ff == 2'd1 || corner_ff == 2'd2) ? u1 : u0;
         out_ff.tex_v        <= (corner_ff == 2'd2 || corner_ff == 2'd3) ? v1 : v0;
         out_ff.vertex_color <= cur_ff.color;
         out_ff.group_slot   <= cur_ff.slot;
         out_ff.quad_index   <= cur_ff.quad;
         out_ff.corner       <= corner_ff;
         out_ff.last         <= corner_ff == 2'd3;
         out_ff.status       <= sqb_pkg::ST_VERTEX;
         out_ff.sprite_total <= cur_ff.total;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.vertex_x     = out_ff.vertex_x;
   assign rsp_chan.vertex_y     = out_ff.vertex_y;
   assign rsp_chan.tex_u        = out_ff.tex_u;
   assign rsp_chan.tex_v        = out_ff.tex_v;
   assign rsp_chan.vertex_color = out_ff.vertex_color;
   assign rsp_chan.group_slot   = out_ff.group_slot;
   assign rsp_chan.quad_index   = out_ff.quad_index;
   assign rsp_chan.corner       = out_ff.corner;
   assign rsp_chan.last         = out_ff.last;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.sprite_total = out_ff.sprite_total;

endmodule

/* tb/sqb_checker.sv */
// checker that predicts sprite quad batcher results from observed requests and compares them
`timescale 1ns / 100ps
module sqb_checker (
   input  logic         clock,
   input  logic         reset,
   sqb_req_if           req_chan,
   sqb_rsp_if           rsp_chan,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   localparam int NG = 16;
   localparam int NQ = 1024;
   localparam int TB = 10;

   sqb_pkg::result_type  vertex_queue[$];
   logic [15:0] bad_tex;
   logic        grp_valid[NG];
   logic [15:0] grp_tex[NG];
   logic [7:0]  grp_layer[NG];
   int          grp_count[NG];
   int          sprites;
   int          mismatches;

   function automatic longint quarter_wave(longint r, longint q);
      longint unsigned x, x2, term;
      longint sum;
      x = (longint'(r) * 64'd1686629713) / q;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 5; n++) begin
         term = (term * x2) >> 30;
         term = term / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) sum = 32768;
      return sum;
   endfunction

   function automatic longint wave(int idx);
      int n, q, qq, r;
      longint v;
      n = 1 << TB;
      q = n >> 2;
      idx = idx & (n - 1);
      qq = idx / q;
      r = idx % q;
      v = (qq & 1) ? quarter_wave(q - r, q) : quarter_wave(r, q);
      return (qq & 2) ? -v : v;
   endfunction

   function automatic longint round15(longint v);
      longint t;
      t = v + 16384;
      if (t >= 0) return t / 32768;
      return -((-t + 32767) / 32768);
   endfunction

   function automatic logic [23:0] clamp24(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
   endfunction

   function automatic sqb_pkg::result_type status_only(sqb_pkg::status_type st);
      sqb_pkg::result_type r;
      r = '0;
      r.last = 1'b1;
      r.status = st;
      r.sprite_total = sprites[15:0];
      return r;
   endfunction

   task automatic queue_result(sqb_pkg::result_type r);
      vertex_queue = {vertex_queue, r};
   endtask

   task automatic predict_request();
      int slot, k;
      int order[4];
      longint c, s, x0, y0, w, h, pvx, pvy, px, py, dx, dy;
      logic [16:0] u0, v0, u1, v1;
      logic [16:0] tu[4], tv[4];
      logic [63:0] src;
      sqb_pkg::result_type r;
      int quad;
      slot = -1;
      if (req_chan.cmd) begin
         for (int i = 0; i < NG; i++) grp_valid[i] = 1'b0;
         sprites = 0;
         queue_result(status_only(sqb_pkg::ST_CLEARED));
         return;
      end
      if (req_chan.texture_id == bad_tex) begin
         queue_result(status_only(sqb_pkg::ST_DROPPED));
         return;
      end
      for (int i = 0; i < NG; i++)
         if (slot < 0 && grp_valid[i] && grp_tex[i] == req_chan.texture_id &&
             grp_layer[i] == req_chan.layer) slot = i;
      if (slot < 0) begin
         for (int i = 0; i < NG; i++) if (slot < 0 && !grp_valid[i]) slot = i;
         if (slot < 0) begin
            queue_result(status_only(sqb_pkg::ST_FULL));
            return;
         end
         grp_valid[slot] = 1'b1;
         grp_tex[slot] = req_chan.texture_id;
         grp_layer[slot] = req_chan.layer;
         grp_count[slot] = 0;
      end
      if (grp_count[slot] >= NQ) begin
         queue_result(status_only(sqb_pkg::ST_FULL));
         return;
      end
      if (req_chan.rotation == 0) begin
         c = 32768;
         s = 0;
      end else begin
         k = req_chan.rotation >> (16 - TB);
         s = wave(k);
         c = wave(k + ((1 << TB) >> 2));
      end
      x0 = longint'($signed(req_chan.dst_x));
      y0 = longint'($signed(req_chan.dst_y));
      w = longint'(req_chan.dst_w);
      h = longint'(req_chan.dst_h);
      pvx = longint'($signed(req_chan.pivot[23:0]));
      pvy = longint'($signed(req_chan.pivot[47:24]));
      px = x0 + pvx;
      py = y0 + pvy;
      src = req_chan.src_rect;
      if (src[47:32] != 0 && src[63:48] != 0) begin
         u0 = {1'b0, src[15:0]};
         v0 = {1'b0, src[31:16]};
         u1 = u0 + {1'b0, src[47:32]};
         v1 = v0 + {1'b0, src[63:48]};
      end else begin
         u0 = 0;
         v0 = 0;
         u1 = sqb_pkg::ONE_Q15;
         v1 = sqb_pkg::ONE_Q15;
      end
      tu = '{u0, u1, u1, u0};
      tv = '{v0, v0, v1, v1};
      order = '{0, 1, 2, 3};
      if (req_chan.flip == sqb_pkg::FLIP_HORIZ) order = '{1, 0, 3, 2};
      else if (req_chan.flip == sqb_pkg::FLIP_VERT) order = '{3, 2, 1, 0};
      quad = grp_count[slot];
      grp_count[slot] = quad + 1;
      if (sprites < 65535) sprites++;
      for (int i = 0; i < 4; i++) begin
         k = order[i];
         dx = (k == 1 || k == 2) ? w - pvx : -pvx;
         dy = (k >= 2) ? h - pvy : -pvy;
         r.vertex_x = clamp24(round15(dx * c - dy * s) + px);
         r.vertex_y = clamp24(round15(dx * s + dy * c) + py);
         r.tex_u = tu[i];
         r.tex_v = tv[i];
         r.vertex_color = req_chan.color;
         r.group_slot = slot[3:0];
         r.quad_index = quad[9:0];
         r.corner = i[1:0];
         r.last = (i == 3);
         r.status = sqb_pkg::ST_VERTEX;
         r.sprite_total = sprites[15:0];
         queue_result(r);
      end
   endtask

   task automatic compare_result();
      sqb_pkg::result_type got, want;
      got = '{rsp_chan.vertex_x, rsp_chan.vertex_y, rsp_chan.tex_u, rsp_chan.tex_v,
              rsp_chan.vertex_color, rsp_chan.group_slot, rsp_chan.quad_index,
              rsp_chan.corner, rsp_chan.last, rsp_chan.status, rsp_chan.sprite_total};
      if (vertex_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = vertex_queue.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bad_tex <= '0;
         sprites = 0;
         for (int i = 0; i < NG; i++) grp_valid[i] = 1'b0;
         vertex_queue.delete();
      end else begin
         if (csr_we) bad_tex <= csr_wdata;
         if (rsp_chan.valid && rsp_chan.ready) compare_result();
         if (req_chan.valid && req_chan.ready) predict_request();
      end
   end

   initial mismatches = 0;
   assign fail_count = mismatches;
   assign pending = vertex_queue.size();
endmodule

/* tb/tb.sv */
// testbench top: drives requests, register writes and result-side stalls for the sprite quad batcher
`timescale 1ns / 100ps
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   sqb_req_if req_chan ();
   sqb_rsp_if rsp_chan ();

   sprite_quad_batcher u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   sqb_checker u_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cmd = 1'b0;
      req_chan.texture_id = '0;
      req_chan.layer = '0;
      req_chan.dst_x = '0;
      req_chan.dst_y = '0;
      req_chan.dst_w = '0;
      req_chan.dst_h = '0;
      req_chan.src_rect = '0;
      req_chan.rotation = '0;
      req_chan.pivot = '0;
      req_chan.flip = '0;
      req_chan.color = '0;
      rsp_chan.ready = 1'b0;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_request(logic cmd, logic [15:0] tex, logic [7:0] layer,
                               logic [23:0] x, logic [23:0] y, logic [22:0] w,
                               logic [22:0] h, logic [63:0] src, logic [15:0] rot,
                               logic [47:0] piv, logic [1:0] flip, logic [31:0] col);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0 && $urandom_range(0, 3) != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.texture_id <= tex;
      req_chan.layer <= layer;
      req_chan.dst_x <= x;
      req_chan.dst_y <= y;
      req_chan.dst_w <= w;
      req_chan.dst_h <= h;
      req_chan.src_rect <= src;
      req_chan.rotation <= rot;
      req_chan.pivot <= piv;
      req_chan.flip <= flip;
      req_chan.color <= col;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic random_draw(logic [15:0] tex, logic [7:0] layer);
      logic [63:0] src;
      logic [23:0] x, y;
      logic [47:0] piv;
      src = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) src[47:32] = '0;
      x = $urandom;
      y = $urandom;
      piv = {$urandom, $urandom};
      if ($urandom_range(0, 1)) begin
         x = $urandom_range(0, 65535) - 32768;
         y = $urandom_range(0, 65535) - 32768;
         piv = {24'($urandom_range(0, 8191)), 24'($urandom_range(0, 8191))};
      end
      send_request(1'b0, tex, layer, x, y, ($urandom_range(0, 3) == 0) ? 23'($urandom)
                   : 23'($urandom_range(0, 16383)), ($urandom_range(0, 3) == 0) ?
                   23'($urandom) : 23'($urandom_range(0, 16383)), src,
                   ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom), piv,
                   2'($urandom_range(0, 3)), $urandom);
   endtask

   task automatic settle_and_write(logic [15:0] value);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [15:0] bad;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value zero drops texture 0
      send_request(1'b0, 16'd0, 8'd0, '0, '0, '0, '0, '0, '0, '0, sqb_pkg::FLIP_NONE, '0);
      send_request(1'b0, 16'hFFFF, 8'hFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
                   23'h7FFFFF, '1, 16'hFFFF, '1, sqb_pkg::FLIP_BOTH, '1);
      send_request(1'b0, 16'd1, 8'd0, 24'h800000, 24'h800000, 23'h7FFFFF,
                   23'h7FFFFF, 64'h0, 16'h0, 48'h800000_800000, sqb_pkg::FLIP_NONE,
                   32'h1234);
      send_request(1'b0, 16'd1, 8'd0, 24'd256, 24'd512, 23'd2560, 23'd1280,
                   64'h4000_4000_1000_2000, 16'h4000, 48'd0, sqb_pkg::FLIP_HORIZ,
                   32'hAABBCCDD);
      send_request(1'b0, 16'd1, 8'd0, 24'd0, 24'd0, 23'd256, 23'd256,
                   64'h0000_4000_0000_0000, 16'h8000, 48'h000080_000080,
                   sqb_pkg::FLIP_VERT, '1);
      send_request(1'b0, 16'd2, 8'd3, 24'd0, 24'd0, 23'd256, 23'd256,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'hC000, 48'h0, sqb_pkg::FLIP_BOTH, '0);
      send_request(1'b0, 16'd2, 8'd3, 24'd0, 24'd0, 23'd1000, 23'd1, '0, 16'd1,
                   48'h0, sqb_pkg::FLIP_NONE, '0);
      // fill the group table then overflow it
      for (int i = 0; i < 17; i++) random_draw(16'(100 + i), 8'd7);
      send_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, sqb_pkg::FLIP_NONE, '0);

      // receiver hold-off while requests keep coming
      hold_off = 1'b1;
      for (int i = 0; i < 12; i++) random_draw(16'd5, 8'd1);
      send_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, sqb_pkg::FLIP_NONE, '0);

      for (int phase = 0; phase < 4; phase++) begin
         bad = (phase == 0) ? 16'hFFFF : (phase == 3) ? 16'd0 : 16'($urandom);
         settle_and_write(bad);
         send_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, sqb_pkg::FLIP_NONE, '0);
         for (int i = 0; i < 52; i++) begin
            case ($urandom_range(0, 9))
               0: send_request(1'b1, 16'($urandom), 8'($urandom), '0, '0, '0, '0, '0,
                               '0, '0, sqb_pkg::FLIP_NONE, '0);
               1: random_draw(bad, 8'($urandom));
               2: random_draw(16'($urandom), 8'($urandom));
               default: random_draw(16'($urandom_range(1, 20)), 8'($urandom_range(0, 1)));
            endcase
         end
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
